// ===== design/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg: shared types and constants for the text terminal char buffer
// Command codes, character codes, FSM states and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package tcb_pkg;

    // Default geometry of the character box
    localparam int NUM_ROWS_DEF = 6;
    localparam int NUM_COLS_DEF = 80;

    // Fixed field widths of the ports
    localparam int CMD_W  = 2;
    localparam int CODE_W = 8;
    localparam int CELL_W = 7;
    localparam int RROW_W = 3;
    localparam int RCOL_W = 7;

    // Character codes
    localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;
    localparam logic [CODE_W-1:0] CODE_LAST  = 8'd127;
    localparam logic [CELL_W-1:0] CELL_SPACE = 7'd32;

    // Command codes carried by the input word
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } tcb_cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_SWEEP   = 2'd0,
        ST_IDLE    = 2'd1,
        ST_EXEC    = 2'd2,
        ST_RD_WAIT = 2'd3
    } tcb_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic in_load;
        logic put_go;
        logic rd_issue;
        logic out_load;
        logic out_is_read;
        logic sweep_all_start;
        logic sweep_row_start;
        logic sweep_step;
    } tcb_ctrl_t;

    // Datapath -> controller status
    typedef struct packed {
        logic is_put;
        logic is_read;
        logic is_clear;
        logic will_scroll;
        logic sweep_last;
        logic out_free;
    } tcb_stat_t;

endpackage

// ===== design/tcb_ram.sv =====
// ----------------------------------------------------------------------------
// tcb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcb_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 480
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/tcb_datapath.sv =====
// ----------------------------------------------------------------------------
// tcb_datapath: cursor, row rotation, cell RAM and result register
// The box scrolls by rotating a top-row pointer; the row that leaves the top
// is blanked by a sweep and reused as the new bottom row.
// ----------------------------------------------------------------------------
module tcb_datapath #(
    parameter int NUM_ROWS = 6,
    parameter int NUM_COLS = 80
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcb_pkg::tcb_ctrl_t         ctrl,
    output tcb_pkg::tcb_stat_t         stat,
    input  logic [tcb_pkg::CMD_W-1:0]  command,
    input  logic [tcb_pkg::CODE_W-1:0] char_code,
    input  logic [tcb_pkg::RROW_W-1:0] read_row,
    input  logic [tcb_pkg::RCOL_W-1:0] read_col,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tcb_pkg::CELL_W-1:0] cell_char,
    output logic [2:0]                 cursor_row,
    output logic [6:0]                 cursor_col,
    output logic                       stored,
    output logic                       scrolled
);

    import tcb_pkg::*;

    localparam int RW    = $clog2(NUM_ROWS);
    localparam int CW    = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int DEPTH = NUM_ROWS * NUM_COLS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [RW-1:0] ROW_LAST = RW'(NUM_ROWS - 1);
    localparam logic [RW:0]   ROWS_X   = (RW + 1)'(NUM_ROWS);
    localparam logic [CW-1:0] COL_LAST = CW'(NUM_COLS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(NUM_COLS);
    localparam logic [AW-1:0] ADDR_END = AW'(DEPTH - 1);

    // Latched input word
    tcb_cmd_t            cmd_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [RROW_W-1:0]   rrow_reg;
    logic [RCOL_W-1:0]   rcol_reg;

    // Cursor and row rotation
    logic [RW-1:0]       cur_row_reg, cur_row_next;
    logic [CW-1:0]       cur_col_reg, cur_col_next;
    logic [RW-1:0]       top_reg, top_next;

    // Blanking sweep
    logic [AW-1:0]       sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]       sweep_last_reg, sweep_last_next;

    // Result register
    logic                out_valid_reg;
    logic [CELL_W-1:0]   cell_char_reg;
    logic [2:0]          cursor_row_reg;
    logic [6:0]          cursor_col_reg;
    logic                stored_reg;
    logic                scrolled_reg;

    // Decode and address signals
    logic                is_newline;
    logic                is_print;
    logic                go_down;
    logic                at_bottom;
    logic                rd_in_range;
    logic [RW+2:0]       rrow_x;
    logic [CW+6:0]       rcol_x;
    logic [RW+2:0]       cur_row_x;
    logic [CW+6:0]       cur_col_x;
    logic [RW+2:0]       row_now_x;
    logic [CW+6:0]       col_now_x;
    logic [AW-1:0]       put_addr;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       row_base;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic [CELL_W-1:0]   rd_data;

    // Logical row -> physical row under the rotation
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] lrow);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, lrow};
        if (sum >= ROWS_X)
        begin
            sum = sum - ROWS_X;
        end
        return sum[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(prow) * COLS_A + AW'(col);
    endfunction

    // Input word latch
    always_ff @(posedge clk)
    begin
        if (ctrl.in_load)
        begin
            cmd_reg  <= tcb_cmd_t'(command);
            code_reg <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
    end

    // Character classification
    assign is_newline = (code_reg == CODE_CR) || (code_reg == CODE_LF);
    assign is_print   = (code_reg >= CODE_SPACE) && (code_reg <= CODE_LAST);
    assign go_down    = is_newline || (is_print && (cur_col_reg == COL_LAST));
    assign at_bottom  = (cur_row_reg == ROW_LAST);

    // Read address, widened then trimmed to the internal widths
    assign rrow_x      = {{RW{1'b0}}, rrow_reg};
    assign rcol_x      = {{CW{1'b0}}, rcol_reg};
    assign rd_in_range = (32'(rrow_reg) < 32'(NUM_ROWS)) &&
                         (32'(rcol_reg) < 32'(NUM_COLS));
    assign rd_addr     = cell_addr(phys_row(top_reg, rrow_x[RW-1:0]), rcol_x[CW-1:0]);
    assign put_addr    = cell_addr(phys_row(top_reg, cur_row_reg), cur_col_reg);
    assign row_base    = cell_addr(top_reg, '0);

    // Cursor update on a put
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        top_next     = top_reg;
        if (ctrl.put_go)
        begin
            if (go_down)
            begin
                cur_col_next = '0;
                if (at_bottom)
                begin
                    top_next = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
                end
                else
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            else if (is_print)
            begin
                cur_col_next = cur_col_reg + 1'b1;
            end
        end
    end

    // Sweep address: whole store, or the row leaving the top
    always_comb
    begin
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        if (ctrl.sweep_all_start)
        begin
            sweep_addr_next = '0;
            sweep_last_next = ADDR_END;
        end
        else if (ctrl.sweep_row_start)
        begin
            sweep_addr_next = row_base;
            sweep_last_next = row_base + COLS_A - 1'b1;
        end
        else if (ctrl.sweep_step)
        begin
            sweep_addr_next = sweep_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= ADDR_END;
        end
        else
        begin
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
        end
    end

    // Cell RAM write: sweep blanks, put stores the character
    assign wr_en   = (ctrl.put_go && is_print) || ctrl.sweep_step;
    assign wr_addr = ctrl.sweep_step ? sweep_addr_reg : put_addr;
    assign wr_data = ctrl.sweep_step ? CELL_SPACE : code_reg[CELL_W-1:0];

    tcb_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctrl.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result register
    assign cur_row_x = {3'b000, cur_row_next};
    assign cur_col_x = {7'b0000000, cur_col_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            cell_char_reg  <= (ctrl.out_is_read && rd_in_range) ? rd_data : '0;
            cursor_row_reg <= cur_row_x[2:0];
            cursor_col_reg <= cur_col_x[6:0];
            stored_reg     <= ctrl.put_go && is_print;
            scrolled_reg   <= ctrl.put_go && stat.will_scroll;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_char  = cell_char_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign stored     = stored_reg;
    assign scrolled   = scrolled_reg;

    // Status to the controller
    assign stat.is_put      = (cmd_reg == CMD_PUT);
    assign stat.is_read     = (cmd_reg == CMD_READ);
    assign stat.is_clear    = (cmd_reg == CMD_CLEAR);
    assign stat.will_scroll = (cmd_reg == CMD_PUT) && go_down && at_bottom;
    assign stat.sweep_last  = (sweep_addr_reg == sweep_last_reg);
    assign stat.out_free    = !out_valid_reg || out_ready;

    // Checks
    assign row_now_x = {3'b000, cur_row_reg};
    assign col_now_x = {7'b0000000, cur_col_reg};

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_row_reg <= ROW_LAST) && (cur_col_reg <= COL_LAST) && (top_reg <= ROW_LAST))
        else $error("cursor or top row out of range");

    a_result_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cursor_row_reg == row_now_x[2:0]) &&
                          (cursor_col_reg == col_now_x[6:0]))
        else $error("cursor moved while a result word is pending");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.put_go && ctrl.sweep_step))
        else $error("put and sweep write the RAM together");

    a_scroll_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.put_go && stat.will_scroll) |=>
            (cur_row_reg == ROW_LAST) && (cur_col_reg == '0))
        else $error("scroll did not leave the cursor at the bottom row start");

    a_put_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.put_go |-> ctrl.out_load && stat.out_free)
        else $error("put executed without loading the result register");

endmodule

// ===== design/tcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcb_ctrl: sequencing FSM of the text terminal char buffer
// Accepts one word, runs it on the datapath, then runs any blanking sweep.
// ----------------------------------------------------------------------------
module tcb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcb_pkg::tcb_stat_t stat,
    output tcb_pkg::tcb_ctrl_t ctrl
);

    import tcb_pkg::*;

    tcb_state_t state_reg, state_next;

    // State register; reset starts with the store blanking sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.in_load = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_read)
                begin
                    ctrl.rd_issue = 1'b1;
                    state_next    = ST_RD_WAIT;
                end
                else if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    ctrl.put_go   = stat.is_put;
                    if (stat.is_clear)
                    begin
                        ctrl.sweep_all_start = 1'b1;
                        state_next           = ST_SWEEP;
                    end
                    else if (stat.is_put && stat.will_scroll)
                    begin
                        ctrl.sweep_row_start = 1'b1;
                        state_next           = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD_WAIT:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load    = 1'b1;
                    ctrl.out_is_read = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                ctrl.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/text_terminal_char_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// text_terminal_char_buffer_unit: text box cell store with cursor and scroll
//
// Input channel (in_valid/in_ready) takes one command word: put a character,
// read a cell, or clear the box. Output channel (out_valid/out_ready) returns
// exactly one result word per command: cell contents for a read, the cursor
// after the command, and stored/scrolled flags.
// Each word is accepted, then executed; a read also waits for the registered
// cell RAM read before its result is loaded. No new word is taken until the
// previous one has executed. A put that scrolls then blanks the new bottom
// row at one cell per cycle, NUM_COLS cells (80 by default); a clear blanks
// all NUM_ROWS*NUM_COLS cells, one per cycle (480 by default). The single
// RAM write port sets this one-cell-per-cycle rate.
// No new word is taken during a blanking sweep.
// After reset the store is blanked the same way: in_ready stays low until all
// NUM_ROWS*NUM_COLS cells (480 by default) are blank; cursor at row 0, column 0.
// A result word waits in the output register while out_ready is low; the
// next word may be accepted meanwhile but its execution holds until the
// output register frees up.
// ----------------------------------------------------------------------------
module text_terminal_char_buffer_unit #(
    parameter int NUM_ROWS = tcb_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLS = tcb_pkg::NUM_COLS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tcb_pkg::CMD_W-1:0]  command,
    input  logic [tcb_pkg::CODE_W-1:0] char_code,
    input  logic [tcb_pkg::RROW_W-1:0] read_row,
    input  logic [tcb_pkg::RCOL_W-1:0] read_col,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tcb_pkg::CELL_W-1:0] cell_char,
    output logic [2:0]                 cursor_row,
    output logic [6:0]                 cursor_col,
    output logic                       stored,
    output logic                       scrolled
);

    import tcb_pkg::*;

    tcb_ctrl_t ctrl;
    tcb_stat_t stat;

    tcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    tcb_datapath #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .command    (command),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_char  (cell_char),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .stored     (stored),
        .scrolled   (scrolled)
    );

endmodule

// ===== verif/tb_text_terminal_char_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_terminal_char_buffer_unit: self-checking bench for the terminal store
// A short probe list covers the reset contents, out-of-range reads, the unused
// command, unprintable codes, newlines and scrolling, and clear. Random
// traffic follows: text lines that wrap and scroll, reads, noise and clears.
// Every result is checked against a typed probe value or a cycle-free box model.
// ----------------------------------------------------------------------------
module tb_text_terminal_char_buffer_unit;
    import tcb_pkg::*;

    localparam int ROWS          = NUM_ROWS_DEF;
    localparam int COLS          = NUM_COLS_DEF;
    localparam int RANDOM_WORDS  = 1750;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 300;
    localparam int PAUSE_AFTER   = 900;
    localparam int SETTLE_CYCLES = 600;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int MAX_SHOWN     = 10;
    localparam int N_PROBES      = 26;

    // One result word
    typedef struct packed {
        logic [6:0] chr;
        logic [2:0] crow;
        logic [6:0] ccol;
        logic       stored;
        logic       scrolled;
    } term_out_t;

    // One probe: command word plus the hand-written result where it is obvious
    typedef struct packed {
        tcb_cmd_t   cmd;
        logic [7:0] code;
        logic [2:0] rrow;
        logic [6:0] rcol;
        logic       typed;
        logic [6:0] w_chr;
        logic [2:0] w_row;
        logic [6:0] w_col;
        logic       w_stored;
        logic       w_scrolled;
    } probe_t;

    localparam probe_t PROBES [N_PROBES] = '{
        // fresh store after reset
        '{CMD_READ,  8'd0,   3'd0, 7'd0,   1'b1, 7'd32,  3'd0, 7'd0, 1'b0, 1'b0},
        '{CMD_READ,  8'd0,   3'd5, 7'd79,  1'b1, 7'd32,  3'd0, 7'd0, 1'b0, 1'b0},
        // reads outside the box
        '{CMD_READ,  8'd0,   3'd7, 7'd127, 1'b1, 7'd0,   3'd0, 7'd0, 1'b0, 1'b0},
        '{CMD_READ,  8'd0,   3'd6, 7'd0,   1'b1, 7'd0,   3'd0, 7'd0, 1'b0, 1'b0},
        '{CMD_READ,  8'd0,   3'd0, 7'd80,  1'b1, 7'd0,   3'd0, 7'd0, 1'b0, 1'b0},
        // unused command
        '{CMD_NOP,   8'd255, 3'd7, 7'd127, 1'b1, 7'd0,   3'd0, 7'd0, 1'b0, 1'b0},
        // printable extremes
        '{CMD_PUT,   8'd65,  3'd0, 7'd0,   1'b1, 7'd0,   3'd0, 7'd1, 1'b1, 1'b0},
        '{CMD_PUT,   8'd127, 3'd0, 7'd0,   1'b1, 7'd0,   3'd0, 7'd2, 1'b1, 1'b0},
        '{CMD_PUT,   8'd32,  3'd7, 7'd127, 1'b0, 7'd0,   3'd0, 7'd0, 1'b0, 1'b0},
        // unprintable codes change nothing
        '{CMD_PUT,   8'd31,  3'd0, 7'd0,   1'b1, 7'd0,   3'd0, 7'd3, 1'b0, 1'b0},
        '{CMD_PUT,   8'd128, 3'd0, 7'd0,   1'b1, 7'd0,   3'd0, 7'd3, 1'b0, 1'b0},
        '{CMD_PUT,   8'd255, 3'd0, 7'd0,   1'b1, 7'd0,   3'd0, 7'd3, 1'b0, 1'b0},
        '{CMD_READ,  8'd0,   3'd0, 7'd0,   1'b1, 7'd65,  3'd0, 7'd3, 1'b0, 1'b0},
        '{CMD_READ,  8'd0,   3'd0, 7'd1,   1'b1, 7'd127, 3'd0, 7'd3, 1'b0, 1'b0},
        // newlines down to the last row, then scroll on both codes
        '{CMD_PUT,   8'd13,  3'd0, 7'd0,   1'b1, 7'd0,   3'd1, 7'd0, 1'b0, 1'b0},
        '{CMD_PUT,   8'd10,  3'd0, 7'd0,   1'b1, 7'd0,   3'd2, 7'd0, 1'b0, 1'b0},
        '{CMD_PUT,   8'd10,  3'd0, 7'd0,   1'b1, 7'd0,   3'd3, 7'd0, 1'b0, 1'b0},
        '{CMD_PUT,   8'd10,  3'd0, 7'd0,   1'b1, 7'd0,   3'd4, 7'd0, 1'b0, 1'b0},
        '{CMD_PUT,   8'd10,  3'd0, 7'd0,   1'b1, 7'd0,   3'd5, 7'd0, 1'b0, 1'b0},
        '{CMD_PUT,   8'd10,  3'd0, 7'd0,   1'b1, 7'd0,   3'd5, 7'd0, 1'b0, 1'b1},
        '{CMD_PUT,   8'd13,  3'd0, 7'd0,   1'b1, 7'd0,   3'd5, 7'd0, 1'b0, 1'b1},
        '{CMD_READ,  8'd0,   3'd2, 7'd0,   1'b0, 7'd0,   3'd0, 7'd0, 1'b0, 1'b0},
        '{CMD_PUT,   8'd122, 3'd0, 7'd0,   1'b1, 7'd0,   3'd5, 7'd1, 1'b1, 1'b0},
        '{CMD_READ,  8'd0,   3'd5, 7'd0,   1'b1, 7'd122, 3'd5, 7'd1, 1'b0, 1'b0},
        // clear keeps the cursor
        '{CMD_CLEAR, 8'd0,   3'd0, 7'd0,   1'b1, 7'd0,   3'd5, 7'd1, 1'b0, 1'b0},
        '{CMD_READ,  8'd0,   3'd5, 7'd0,   1'b1, 7'd32,  3'd5, 7'd1, 1'b0, 1'b0}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [7:0] char_code;
    logic [2:0] read_row;
    logic [6:0] read_col;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] cell_char;
    logic [2:0] cursor_row;
    logic [6:0] cursor_col;
    logic       stored;
    logic       scrolled;

    // Model of the box
    logic [6:0] screen [ROWS][COLS];
    int         row_now;
    int         col_now;

    term_out_t  pending_results [$];
    int         n_sent;
    int         n_results;
    int         n_stored;
    int         n_scrolls;
    int         n_reads;
    int         n_clears;
    int         err_count;
    int         shown;
    bit         tx_steady;

    text_terminal_char_buffer_unit #(
        .NUM_ROWS (ROWS),
        .NUM_COLS (COLS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_char  (cell_char),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .stored     (stored),
        .scrolled   (scrolled)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void blank_screen();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                screen[r][c] = CELL_SPACE;
    endfunction

    // Cursor to column 0 of the next row; scrolls at the bottom
    function automatic bit next_line();
        col_now = 0;
        if (row_now + 1 >= ROWS)
        begin
            for (int r = 0; r < ROWS - 1; r++)
                for (int c = 0; c < COLS; c++)
                    screen[r][c] = screen[r + 1][c];
            for (int c = 0; c < COLS; c++)
                screen[ROWS - 1][c] = CELL_SPACE;
            row_now = ROWS - 1;
            return 1'b1;
        end
        row_now++;
        return 1'b0;
    endfunction

    // Apply one command word to the model and return the result word it gives
    function automatic term_out_t apply_command(tcb_cmd_t cmd, logic [7:0] code,
                                                logic [2:0] rrow, logic [6:0] rcol);
        term_out_t r;
        r = '0;
        case (cmd)
            CMD_PUT:
            begin
                if (code == CODE_CR || code == CODE_LF)
                    r.scrolled = next_line();
                else if (code >= CODE_SPACE && code <= CODE_LAST)
                begin
                    screen[row_now][col_now] = code[6:0];
                    r.stored = 1'b1;
                    col_now++;
                    if (col_now >= COLS)
                        r.scrolled = next_line();
                end
            end
            CMD_READ:
            begin
                n_reads++;
                if (rrow < ROWS && rcol < COLS)
                    r.chr = screen[rrow][rcol];
            end
            CMD_CLEAR:
            begin
                n_clears++;
                blank_screen();
            end
            default: ;
        endcase
        r.crow = row_now[2:0];
        r.ccol = col_now[6:0];
        n_stored  += int'(r.stored);
        n_scrolls += int'(r.scrolled);
        return r;
    endfunction

    // Offer one word after a random gap; called and returns at a falling edge
    task automatic send_word(input tcb_cmd_t cmd, input logic [7:0] code,
                             input logic [2:0] rrow, input logic [6:0] rcol,
                             input bit has_want, input term_out_t want);
        int        gap;
        term_out_t predicted;
        if (n_sent % 64 == 0)
            tx_steady = ($urandom_range(0, 3) == 0);
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        char_code <= code;
        read_row  <= rrow;
        read_col  <= rcol;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_command(cmd, code, rrow, rcol);
        pending_results.push_back(has_want ? want : predicted);
        n_sent++;
        @(negedge clk);
    endtask

    // Result side: random stalls, one long hold-off to back the block up
    initial
    begin
        int  stall;
        int  rx_cnt;
        bit  rx_steady;
        bit  held;
        out_ready = 1'b0;
        rx_cnt    = 0;
        rx_steady = 1'b0;
        held      = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_cnt % 64 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            stall = rx_steady ? 0 : $urandom_range(0, 15);
            if (!held && n_results >= HOLD_AFTER)
            begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            rx_cnt++;
            @(negedge clk);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        term_out_t got;
        term_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{cell_char, cursor_row, cursor_col, stored, scrolled};
            n_results++;
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (shown < MAX_SHOWN)
                    $display("[%0t] unexpected word: char=%0d row=%0d col=%0d st=%b sc=%b",
                             $realtime, got.chr, got.crow, got.ccol, got.stored,
                             got.scrolled);
                shown++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.chr !== want.chr || got.crow !== want.crow ||
                    got.ccol !== want.ccol || got.stored !== want.stored ||
                    got.scrolled !== want.scrolled)
                begin
                    err_count++;
                    if (shown < MAX_SHOWN)
                    begin
                        $display("[%0t] word %0d mismatch", $realtime, n_results - 1);
                        $display("    expected char=%0d row=%0d col=%0d st=%b sc=%b",
                                 want.chr, want.crow, want.ccol, want.stored,
                                 want.scrolled);
                        $display("    actual   char=%0d row=%0d col=%0d st=%b sc=%b",
                                 got.chr, got.crow, got.ccol, got.stored, got.scrolled);
                    end
                    shown++;
                end
            end
        end
    end

    // Watchdog: worst case is ~1800 words each with a full clear sweep plus
    // max gap and stall, about 3.7 ms; allow over five times that
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        logic [7:0] code;
        int         kind;
        int         len;
        int         drain;
        bit         paused;
        probe_t     p;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = CMD_NOP;
        char_code = '0;
        read_row  = '0;
        read_col  = '0;
        n_sent    = 0;
        n_results = 0;
        n_stored  = 0;
        n_scrolls = 0;
        n_reads   = 0;
        n_clears  = 0;
        err_count = 0;
        shown     = 0;
        tx_steady = 1'b0;
        paused    = 1'b0;
        row_now   = 0;
        col_now   = 0;
        blank_screen();

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed probes
        for (int i = 0; i < N_PROBES; i++)
        begin
            p = PROBES[i];
            send_word(p.cmd, p.code, p.rrow, p.rcol, p.typed,
                      '{p.w_chr, p.w_row, p.w_col, p.w_stored, p.w_scrolled});
        end

        // Random traffic, mostly text lines
        while (n_sent < N_PROBES + RANDOM_WORDS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                // a line of text, long enough at times to wrap
                len = $urandom_range(1, 100);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 99) < 3)
                        code = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 31))
                                                           : 8'($urandom_range(128, 255));
                    else
                        code = 8'($urandom_range(32, 127));
                    send_word(CMD_PUT, code, 3'($urandom_range(0, 7)),
                              7'($urandom_range(0, 127)), 1'b0, '0);
                end
                if ($urandom_range(0, 9) < 7)
                    send_word(CMD_PUT, ($urandom_range(0, 1) != 0) ? CODE_CR : CODE_LF,
                              3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                              1'b0, '0);
            end
            else if (kind < 85)
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_word(CMD_READ, 8'($urandom_range(0, 255)),
                                  3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                                  1'b0, '0);
                    else
                        send_word(CMD_READ, 8'($urandom_range(0, 255)),
                                  3'($urandom_range(0, ROWS - 1)),
                                  7'($urandom_range(0, COLS - 1)), 1'b0, '0);
                end
            end
            else if (kind < 92)
            begin
                // noise put, any code
                send_word(CMD_PUT, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)), 1'b0, '0);
            end
            else if (kind < 97)
                send_word(CMD_NOP, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)), 1'b0, '0);
            else
                send_word(CMD_CLEAR, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          7'($urandom_range(0, 127)), 1'b0, '0);

            // once, let the block drain completely before going on
            if (!paused && n_sent >= PAUSE_AFTER)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
        end
        in_valid <= 1'b0;

        // Drain, then watch for stray words
        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d result words never arrived", pending_results.size());
            err_count += pending_results.size();
        end

        $display("Sent %0d words, checked %0d results: %0d chars stored, %0d scrolls,",
                 n_sent, n_results, n_stored, n_scrolls);
        $display("%0d cell reads, %0d clears; %0d errors", n_reads, n_clears, err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
